/* rtl/tbnp_pkg.sv */
// ----------------------------------------------------------------------------
// tbnp_pkg
// Shared widths, types and the symbol lookup for the text base-n packer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbnp_pkg;

	// accumulator geometry
	localparam int ACC_WORDS = 8;
	localparam int WORD_W    = 64;
	localparam int IDX_W     = (ACC_WORDS > 1) ? $clog2(ACC_WORDS) : 1;
	localparam int CNT_W     = $clog2(ACC_WORDS + 1);
	localparam int WNUM_W    = 3;

	// character and symbol widths
	localparam int CHAR_W    = 8;
	localparam int SYM_W     = 6;
	localparam int RADIX_W   = 6;
	localparam int PROD_W    = WORD_W + RADIX_W;

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_RADIX = 1'b0;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd42;

	// result of an alphabet lookup
	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] idx;
	} sym_t;

	// alphabet " -./0123456789?@A..Z", lower case folded to upper case
	function automatic sym_t sym_lookup(input logic [CHAR_W-1:0] code);
		logic [CHAR_W-1:0] c;
		sym_t              r;
		c     = code;
		r.hit = 1'b1;
		r.idx = '0;
		if (c >= 8'h61 && c <= 8'h7a) begin
			c = c - 8'd32;
		end
		if (c == 8'h20) begin
			r.idx = 6'd0;
		end else if (c == 8'h2d) begin
			r.idx = 6'd1;
		end else if (c == 8'h2e) begin
			r.idx = 6'd2;
		end else if (c == 8'h2f) begin
			r.idx = 6'd3;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.idx = SYM_W'(c - 8'd44);
		end else if (c == 8'h3f) begin
			r.idx = 6'd14;
		end else if (c == 8'h40) begin
			r.idx = 6'd15;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			r.idx = SYM_W'(c - 8'd49);
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/tbnp_if.sv */
// ----------------------------------------------------------------------------
// tbnp channel interfaces
// Character item channel and packed word item channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbnp_char_if
	import tbnp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface tbnp_word_if
	import tbnp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] packed_word;
	logic [WNUM_W-1:0] word_number;
	logic              final_word;

	modport source (output valid, output packed_word, output word_number,
		output final_word, input ready);
	modport sink   (input valid, input packed_word, input word_number,
		input final_word, output ready);
endinterface

`default_nettype wire

/* rtl/text_base_n_packer_core.sv */
// ----------------------------------------------------------------------------
// text_base_n_packer_core
// Packs a character string into a wide integer, acc = acc*radix + index,
// with the accumulator words held in a synchronous RAM with one read and one
// write port.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------
//  chars    | in  | char_code[7:0], end_of_text               | valid/ready
//  words    | out | packed_word[63:0], word_number[2:0], final | valid/ready
//  apb      | in  | paddr[2:0], pwdata[31:0] -> prdata         | psel/penable
//
//  each character takes one pass over the word RAM, one read per cycle unless
//  stalled, the multiply-add working on the registered read data
//  on end_of_text the pass sends each updated word out and clears the entry
//  a full output register stalls the pass until the word is taken
//  after reset the accumulator reads as zero through per-word valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module text_base_n_packer_core
	import tbnp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	tbnp_char_if.sink               chars,
	tbnp_word_if.source             words
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t               state_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic [IDX_W-1:0]     idx_s2;
	logic                 live_s2;
	logic                 vld_s2;
	logic [WORD_W-1:0]    rdata_s2;
	logic [RADIX_W-1:0]   mult_q;
	logic [RADIX_W-1:0]   carry_q;
	logic                 eot_q;
	logic [ACC_WORDS-1:0] vld_q;
	logic [WORD_W-1:0]    mem [ACC_WORDS];

	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_word_q;
	logic [WNUM_W-1:0]    out_num_q;
	logic                 out_final_q;

	logic                 reg_idx_ok;
	logic                 cfg_wr;
	logic                 stall;
	logic                 advance;
	logic                 rd_more;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic                 proc;
	logic                 last_s2;
	logic [WORD_W-1:0]    word_s2;
	logic [PROD_W-1:0]    prod_s2;
	logic                 wr_en;
	sym_t                 sym;

	// register port
	assign pready     = 1'b1;
	assign reg_idx_ok = (paddr[PADDR_W-1:2] == REG_RADIX);
	assign cfg_wr     = psel && penable && pwrite && pready && reg_idx_ok;
	assign prdata     = reg_idx_ok ? PDATA_W'(radix_q) : '0;

	// sequencing of the word pass
	assign sym     = sym_lookup(chars.char_code);
	assign chars.ready = (state_q == ST_IDLE);
	assign stall   = live_s2 && eot_q && out_valid_q && !words.ready;
	assign advance = !stall;
	assign rd_more = (state_q == ST_RUN) && (rd_cnt_q < CNT_W'(ACC_WORDS));
	assign rd_en   = advance && rd_more;
	assign rd_addr = rd_cnt_q[IDX_W-1:0];
	assign proc    = live_s2 && advance;
	assign last_s2 = (idx_s2 == IDX_W'(ACC_WORDS - 1));
	assign wr_en   = proc && !eot_q;

	// multiply-add on one word, carry into the next
	assign word_s2 = vld_s2 ? rdata_s2 : '0;
	assign prod_s2 = PROD_W'(word_s2) * PROD_W'(mult_q) + PROD_W'(carry_q);

	// accumulator word memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s2 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[idx_s2] <= prod_s2[WORD_W-1:0];
		end
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_RESET;
			rd_cnt_q    <= '0;
			idx_s2      <= '0;
			live_s2     <= 1'b0;
			vld_s2      <= 1'b0;
			mult_q      <= '0;
			carry_q     <= '0;
			eot_q       <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				radix_q <= pwdata[RADIX_W-1:0];
			end
			// output register loads a flushed word, empties once taken
			if (proc && eot_q) begin
				out_valid_q <= 1'b1;
			end else if (words.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (chars.valid) begin
						state_q  <= ST_RUN;
						rd_cnt_q <= '0;
						eot_q    <= chars.end_of_text;
						// a skipped character runs an identity pass
						mult_q   <= sym.hit ? radix_q : RADIX_W'(1);
						carry_q  <= sym.hit ? sym.idx : '0;
					end
				end
				ST_RUN: begin
					if (advance) begin
						live_s2 <= rd_more;
						if (rd_more) begin
							idx_s2   <= rd_addr;
							vld_s2   <= vld_q[rd_addr];
							rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						end
					end
					if (proc) begin
						carry_q       <= prod_s2[PROD_W-1:WORD_W];
						vld_q[idx_s2] <= !eot_q;
						if (last_s2) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (proc && eot_q) begin
			out_word_q  <= prod_s2[WORD_W-1:0];
			out_num_q   <= WNUM_W'(idx_s2);
			out_final_q <= last_s2;
		end
	end

	assign words.valid       = out_valid_q;
	assign words.packed_word = out_word_q;
	assign words.word_number = out_num_q;
	assign words.final_word  = out_final_q;

endmodule

`default_nettype wire

/* rtl/tbnp_checker.sv */
// ----------------------------------------------------------------------------
// tbnp_checker
// Port-level checks of the packer: word order, pairing with end_of_text,
// hold of a stalled word item, and no character taken before the final word item.
// ----------------------------------------------------------------------------
`default_nettype none

module tbnp_checker
	import tbnp_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              chars_valid,
	input wire logic              chars_ready,
	input wire logic              chars_eot,
	input wire logic              words_valid,
	input wire logic              words_ready,
	input wire logic [WORD_W-1:0] words_data,
	input wire logic [WNUM_W-1:0] words_num,
	input wire logic              words_final
);

	logic              char_acc;
	logic              word_acc;
	logic              text_in;
	logic              text_out;
	logic [1:0]        pend_q;
	logic [WNUM_W-1:0] exp_num_q;

	assign char_acc = chars_valid && chars_ready;
	assign word_acc = words_valid && words_ready;
	assign text_in  = char_acc && chars_eot;
	assign text_out = word_acc && words_final;

	// count end_of_text items whose words are not all out, track the expected word number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			exp_num_q <= '0;
		end else begin
			if (text_in && !text_out) begin
				pend_q <= pend_q + 2'd1;
			end else if (!text_in && text_out) begin
				pend_q <= pend_q - 2'd1;
			end
			if (word_acc) begin
				exp_num_q <= words_final ? '0 : exp_num_q + WNUM_W'(1);
			end
		end
	end

	// a stalled word item stays valid and keeps its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		words_valid && !words_ready |=> words_valid && $stable(words_data))
		else $error("word item changed while stalled");

	// words come out in order, least significant first
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		word_acc |-> words_num == exp_num_q)
		else $error("word item out of order");

	// the last word is the most significant one
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		word_acc && words_final |-> words_num == WNUM_W'(ACC_WORDS - 1))
		else $error("final word at wrong position");

	// words only follow an end_of_text item
	a_paired: assert property (@(posedge clk) disable iff (!arst_n)
		word_acc |-> pend_q != 2'd0)
		else $error("word item without end of text");

	// next character only once the pass has reached the last word
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		char_acc && pend_q != 2'd0 |-> words_valid && words_final)
		else $error("character taken during word output");

endmodule

bind text_base_n_packer_core tbnp_checker u_tbnp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.chars_valid (chars.valid),
	.chars_ready (chars.ready),
	.chars_eot   (chars.end_of_text),
	.words_valid (words.valid),
	.words_ready (words.ready),
	.words_data  (words.packed_word),
	.words_num   (words.word_number),
	.words_final (words.final_word)
);

`default_nettype wire
